// File: rtl/stramp_pkg.sv
// ----------------------------------------------------------------------------
// stramp_pkg
// Shared types and constants of the trapezoidal stepper ramp unit.
// ----------------------------------------------------------------------------
package stramp_pkg;

    localparam int MOVE_W     = 25;   // signed step count of a move item
    localparam int PERIOD_W   = 32;   // timer reload value of a result item
    localparam int RATE_W     = 16;   // accel, decel and speed registers
    localparam int SCALE_W    = 32;   // scale registers
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Shared divider: wide enough for every planning and ramp quotient.
    localparam int DIV_W      = 48;
    localparam int DIV_CNT_W  = 6;
    localparam int REM_W      = 33;
    localparam int SQRT_W     = 32;

    localparam int ONE_STEP_DELAY = 1000;

    localparam logic ITEM_MOVE = 1'b0;
    localparam logic ITEM_TICK = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_ACCEL_RATE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECEL_RATE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOP_SPEED   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_START_SCALE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_SCALE = 3'd5;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_RUN   = 2'd2,
        PH_DECEL = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FLOOR_GO,
        ST_FLOOR_END,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_SQ_GO,
        ST_LIM_GO,
        ST_LIM_END,
        ST_SPLIT_GO,
        ST_SPLIT_END,
        ST_DEC_GO,
        ST_DEC_END,
        ST_FINISH,
        ST_TICK,
        ST_TICK_END,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// File: rtl/stramp_in_if.sv
// ----------------------------------------------------------------------------
// stramp_in_if
// Input channel of the ramp unit: move and tick items.
// ----------------------------------------------------------------------------
interface stramp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [stramp_pkg::MOVE_W-1:0] move_steps;

    modport source (output valid, kind, move_steps, input ready);
    modport sink   (input valid, kind, move_steps, output ready);
endinterface

// File: rtl/stramp_out_if.sv
// ----------------------------------------------------------------------------
// stramp_out_if
// Output channel of the ramp unit: pin level, direction, period and phase.
// ----------------------------------------------------------------------------
interface stramp_out_if;
    logic                            valid;
    logic                            ready;
    logic                            pulse_level;
    logic                            direction;
    logic [stramp_pkg::PERIOD_W-1:0] period;
    logic [1:0]                      phase;

    modport source (output valid, pulse_level, direction, period, phase, input ready);
    modport sink   (input valid, pulse_level, direction, period, phase, output ready);
endinterface

// File: rtl/stepper_trapezoid_ramp_unit.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_unit
// Trapezoidal stepper speed ramp with planner and remainder-carrying recurrence.
// ----------------------------------------------------------------------------
// Every item gives one result item. A tick item in accel or decel is set up, takes
// one pass of the shared radix-2 divider, updates the ramp state and goes to the
// output; a tick in run or stop skips the divider, and a zero-step or one-step move
// goes straight to the output. A move of two or more steps plans the profile with
// two to five divider passes and, unless the accel rate is zero, a 16-step square
// root. Items are taken one at a time; the result sits in an output register, so
// the next item is accepted while it waits, and a full output register holds the
// block in its output state. Configuration goes through the APB port; the user
// must write it only while idle, as the block itself does not enforce this.
module stepper_trapezoid_ramp_unit #(
    parameter int STEP_BITS  = 24,
    parameter int DELAY_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    stramp_in_if.sink                              i_item,
    stramp_out_if.source                           o_item,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [stramp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [stramp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stramp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                   pready
);

    localparam int CNT_W = STEP_BITS + 1;
    localparam int DW    = stramp_pkg::DIV_W;
    localparam logic [STEP_BITS-1:0]  STEP_MAX    = {STEP_BITS{1'b1}};
    localparam logic [DELAY_BITS-1:0] DELAY_MAX   = {DELAY_BITS{1'b1}};
    localparam logic [DW-1:0]         STEP_MAX_D  = DW'(STEP_MAX);
    localparam logic [DW-1:0]         DELAY_MAX_D = DW'(DELAY_MAX);

    // Configuration registers
    logic [stramp_pkg::RATE_W-1:0]  r_accel_rate, r_decel_rate, r_top_speed;
    logic [stramp_pkg::SCALE_W-1:0] r_speed_scale, r_start_scale, r_limit_scale;

    // Sequencer and ramp state
    stramp_pkg::t_state r_state, n_state, r_ret, n_ret;
    stramp_pkg::t_phase r_phase, n_phase;
    logic                   r_dir, n_dir, r_pulse, n_pulse;
    logic [DELAY_BITS-1:0]  r_delay, n_delay, r_floor, n_floor;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [stramp_pkg::REM_W-1:0] r_rem, n_rem;
    logic [STEP_BITS-1:0]   r_acc_steps, n_acc_steps, r_run_steps, n_run_steps;
    logic [STEP_BITS-1:0]   r_dec_steps, n_dec_steps;

    // Planning scratch
    logic [STEP_BITS-1:0]   r_n, n_n, r_lim_steps, n_lim_steps, r_acc, n_acc, r_dec, n_dec;
    logic [DW-1:0]          r_prod, n_prod;

    // Shared divider and root unit
    logic [DW-1:0]                     r_dq, n_dq, r_dr, n_dr, r_dd, n_dd;
    logic [stramp_pkg::DIV_CNT_W-1:0]  r_dcnt, n_dcnt;
    logic [stramp_pkg::SQRT_W-1:0]     r_sv, n_sv, r_sr, n_sr, r_sbit, n_sbit;

    // Output register
    logic                   r_out_valid, n_out_valid, r_out_pulse, n_out_pulse;
    logic                   r_out_dir, n_out_dir;
    logic [stramp_pkg::PERIOD_W-1:0] r_out_period, n_out_period;
    logic [1:0]             r_out_phase, n_out_phase;

    // Shared multiplier
    logic [31:0]                   mul_a;
    logic [stramp_pkg::RATE_W-1:0] mul_b;
    logic [DW-1:0]                 mul_p;

    logic                    in_fire;
    logic                    move_neg;
    logic [stramp_pkg::MOVE_W-1:0] move_abs;
    logic [31:0]             move_mag32;
    logic [STEP_BITS-1:0]    move_mag;
    logic [DW:0]             div_sh;
    logic [DW+1:0]           div_diff;
    logic                    div_qbit;
    logic [stramp_pkg::SQRT_W-1:0] sq_t;
    logic                    sq_take;
    logic [31:0]             rate_sum;
    logic                    split_short;
    logic [CNT_W-1:0]        cnt_up, cnt_down;
    logic                    out_free;
    logic [STEP_BITS:0]      ad_sum;
    logic [DW:0]             dec_sum;

    assign pready         = 1'b1;
    assign i_item.ready   = (r_state == stramp_pkg::ST_IDLE);
    assign in_fire        = i_item.valid && (r_state == stramp_pkg::ST_IDLE);
    assign out_free       = !r_out_valid || o_item.ready;

    assign o_item.valid       = r_out_valid;
    assign o_item.pulse_level = r_out_pulse;
    assign o_item.direction   = r_out_dir;
    assign o_item.period      = r_out_period;
    assign o_item.phase       = r_out_phase;

    // Magnitude of the move, saturated to the step range.
    assign move_neg   = i_item.move_steps[stramp_pkg::MOVE_W-1];
    assign move_abs   = move_neg ? (~i_item.move_steps + 1'b1) : i_item.move_steps;
    assign move_mag32 = 32'(move_abs);
    assign move_mag   = (move_mag32 > 32'(STEP_MAX)) ? STEP_MAX
                                                     : move_mag32[STEP_BITS-1:0];

    assign rate_sum    = 32'(r_accel_rate) + 32'(r_decel_rate);
    assign split_short = rate_sum >= 32'(r_n);
    assign cnt_up      = r_count + 1'b1;
    assign cnt_down    = (r_count != '0) ? (r_count - 1'b1) : '0;
    assign ad_sum      = {1'b0, r_acc} + {1'b0, r_dec};
    assign dec_sum     = {1'b0, DW'(r_delay)} + {1'b0, r_dq};

    // Restoring divider step: one quotient bit per cycle.
    assign div_sh   = {r_dr, r_dq[DW-1]};
    assign div_diff = {1'b0, div_sh} - {2'b00, r_dd};
    assign div_qbit = !div_diff[DW+1];

    // Integer square root step: two radicand bits per cycle.
    assign sq_t    = r_sr + r_sbit;
    assign sq_take = r_sv >= sq_t;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            stramp_pkg::ST_SQ_GO: begin
                mul_a = 32'(r_top_speed);
                mul_b = r_top_speed;
            end
            stramp_pkg::ST_LIM_GO: begin
                mul_a = r_limit_scale;
                mul_b = r_accel_rate;
            end
            stramp_pkg::ST_SPLIT_GO: begin
                mul_a = 32'(r_n);
                mul_b = r_decel_rate;
            end
            stramp_pkg::ST_DEC_GO: begin
                mul_a = 32'(r_lim_steps);
                mul_b = r_accel_rate;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = DW'(mul_a) * DW'(mul_b);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stramp_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_item.kind == stramp_pkg::ITEM_TICK) begin
                        n_state = stramp_pkg::ST_TICK;
                    end else if (move_mag > STEP_BITS'(1)) begin
                        n_state = stramp_pkg::ST_FLOOR_GO;
                    end else begin
                        n_state = stramp_pkg::ST_OUT;
                    end
                end
            end
            stramp_pkg::ST_FLOOR_GO:  n_state = stramp_pkg::ST_DIV;
            stramp_pkg::ST_FLOOR_END: begin
                n_state = (r_accel_rate == '0) ? stramp_pkg::ST_SQ_GO : stramp_pkg::ST_DIV;
            end
            stramp_pkg::ST_SQRT_INIT: n_state = stramp_pkg::ST_SQRT;
            stramp_pkg::ST_SQRT: begin
                if (r_sbit == '0) begin
                    n_state = stramp_pkg::ST_SQ_GO;
                end
            end
            stramp_pkg::ST_SQ_GO:     n_state = stramp_pkg::ST_LIM_GO;
            stramp_pkg::ST_LIM_GO:    n_state = stramp_pkg::ST_DIV;
            stramp_pkg::ST_LIM_END: begin
                n_state = split_short ? stramp_pkg::ST_SPLIT_GO : stramp_pkg::ST_FINISH;
            end
            stramp_pkg::ST_SPLIT_GO:  n_state = stramp_pkg::ST_DIV;
            stramp_pkg::ST_SPLIT_END: begin
                n_state = (r_lim_steps > r_dq[STEP_BITS-1:0]) ? stramp_pkg::ST_FINISH
                                                              : stramp_pkg::ST_DEC_GO;
            end
            stramp_pkg::ST_DEC_GO:    n_state = stramp_pkg::ST_DIV;
            stramp_pkg::ST_DEC_END:   n_state = stramp_pkg::ST_FINISH;
            stramp_pkg::ST_FINISH:    n_state = stramp_pkg::ST_OUT;
            stramp_pkg::ST_TICK: begin
                if (r_phase == stramp_pkg::PH_ACCEL || r_phase == stramp_pkg::PH_DECEL) begin
                    n_state = stramp_pkg::ST_DIV;
                end else begin
                    n_state = stramp_pkg::ST_OUT;
                end
            end
            stramp_pkg::ST_TICK_END:  n_state = stramp_pkg::ST_OUT;
            stramp_pkg::ST_DIV: begin
                if (r_dcnt == stramp_pkg::DIV_CNT_W'(DW - 1)) begin
                    n_state = r_ret;
                end
            end
            stramp_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = stramp_pkg::ST_IDLE;
                end
            end
            default: n_state = stramp_pkg::ST_IDLE;
        endcase
    end

    // Datapath
    always_comb begin
        n_ret       = r_ret;
        n_phase     = r_phase;
        n_dir       = r_dir;
        n_pulse     = r_pulse;
        n_delay     = r_delay;
        n_floor     = r_floor;
        n_count     = r_count;
        n_rem       = r_rem;
        n_acc_steps = r_acc_steps;
        n_run_steps = r_run_steps;
        n_dec_steps = r_dec_steps;
        n_n         = r_n;
        n_lim_steps = r_lim_steps;
        n_acc       = r_acc;
        n_dec       = r_dec;
        n_prod      = r_prod;
        n_dq        = r_dq;
        n_dr        = r_dr;
        n_dd        = r_dd;
        n_dcnt      = r_dcnt;
        n_sv        = r_sv;
        n_sr        = r_sr;
        n_sbit      = r_sbit;
        n_out_valid  = r_out_valid && !o_item.ready;
        n_out_pulse  = r_out_pulse;
        n_out_dir    = r_out_dir;
        n_out_period = r_out_period;
        n_out_phase  = r_out_phase;

        unique case (r_state)
            stramp_pkg::ST_IDLE: begin
                if (in_fire && i_item.kind == stramp_pkg::ITEM_MOVE && move_mag != '0) begin
                    n_dir = move_neg;
                    n_n   = move_mag;
                    if (move_mag == STEP_BITS'(1)) begin
                        n_delay = DELAY_BITS'(stramp_pkg::ONE_STEP_DELAY);
                        n_count = CNT_W'(1);
                        n_rem   = '0;
                        n_phase = stramp_pkg::PH_DECEL;
                    end
                end
            end
            stramp_pkg::ST_FLOOR_GO: begin
                n_dq   = DW'(r_speed_scale);
                n_dr   = '0;
                n_dd   = DW'(r_top_speed);
                n_dcnt = '0;
                n_ret  = stramp_pkg::ST_FLOOR_END;
            end
            stramp_pkg::ST_FLOOR_END: begin
                n_floor = (r_dq > DELAY_MAX_D) ? DELAY_MAX : r_dq[DELAY_BITS-1:0];
                if (r_accel_rate == '0) begin
                    n_delay = DELAY_MAX;
                end else begin
                    n_dq   = DW'(r_start_scale);
                    n_dr   = '0;
                    n_dd   = DW'(r_accel_rate);
                    n_dcnt = '0;
                    n_ret  = stramp_pkg::ST_SQRT_INIT;
                end
            end
            stramp_pkg::ST_SQRT_INIT: begin
                n_sv   = r_dq[stramp_pkg::SQRT_W-1:0];
                n_sr   = '0;
                n_sbit = stramp_pkg::SQRT_W'(1) << (stramp_pkg::SQRT_W - 2);
            end
            stramp_pkg::ST_SQRT: begin
                if (r_sbit == '0) begin
                    // The root stays below 2^16 and fits a delay width of 16 bits or more.
                    n_delay = DELAY_BITS'(r_sr);
                end else begin
                    if (sq_take) begin
                        n_sv = r_sv - sq_t;
                        n_sr = (r_sr >> 1) + r_sbit;
                    end else begin
                        n_sr = r_sr >> 1;
                    end
                    n_sbit = r_sbit >> 2;
                end
            end
            stramp_pkg::ST_SQ_GO: begin
                n_prod = mul_p;
            end
            stramp_pkg::ST_LIM_GO: begin
                n_dq   = r_prod << 16;
                n_dr   = '0;
                n_dd   = mul_p;
                n_dcnt = '0;
                n_ret  = stramp_pkg::ST_LIM_END;
            end
            stramp_pkg::ST_LIM_END: begin
                n_lim_steps = (r_dq > STEP_MAX_D) ? STEP_MAX : r_dq[STEP_BITS-1:0];
                if (!split_short) begin
                    n_acc = (32'(r_accel_rate) > 32'(STEP_MAX)) ? STEP_MAX
                                                                : STEP_BITS'(r_accel_rate);
                    n_dec = (32'(r_decel_rate) > 32'(STEP_MAX)) ? STEP_MAX
                                                                : STEP_BITS'(r_decel_rate);
                end
            end
            stramp_pkg::ST_SPLIT_GO: begin
                n_dq   = mul_p;
                n_dr   = '0;
                n_dd   = DW'(rate_sum);
                n_dcnt = '0;
                n_ret  = stramp_pkg::ST_SPLIT_END;
            end
            stramp_pkg::ST_SPLIT_END: begin
                // The split point never exceeds the move length.
                n_acc = r_dq[STEP_BITS-1:0];
                if (r_lim_steps > r_dq[STEP_BITS-1:0]) begin
                    n_dec = r_n - r_dq[STEP_BITS-1:0];
                end
            end
            stramp_pkg::ST_DEC_GO: begin
                n_dq   = mul_p;
                n_dr   = '0;
                n_dd   = DW'(r_decel_rate);
                n_dcnt = '0;
                n_ret  = stramp_pkg::ST_DEC_END;
            end
            stramp_pkg::ST_DEC_END: begin
                n_dec = (r_dq > STEP_MAX_D) ? STEP_MAX : r_dq[STEP_BITS-1:0];
            end
            stramp_pkg::ST_FINISH: begin
                n_acc_steps = r_acc;
                n_dec_steps = r_dec;
                n_run_steps = (ad_sum > {1'b0, r_n}) ? '0 : STEP_BITS'({1'b0, r_n} - ad_sum);
                n_count     = '0;
                n_rem       = '0;
                n_phase     = stramp_pkg::PH_ACCEL;
            end
            stramp_pkg::ST_TICK: begin
                if (r_phase != stramp_pkg::PH_STOP) begin
                    n_pulse = !r_pulse;
                end
                n_dq   = DW'({r_delay, 1'b0}) + DW'(r_rem);
                n_dr   = '0;
                n_dcnt = '0;
                n_ret  = stramp_pkg::ST_TICK_END;
                unique case (r_phase)
                    stramp_pkg::PH_ACCEL: begin
                        n_count = cnt_up;
                        n_dd    = DW'({cnt_up, 2'b01});
                    end
                    stramp_pkg::PH_DECEL: begin
                        n_count = cnt_down;
                        n_dd    = DW'({cnt_down, 2'b01});
                    end
                    stramp_pkg::PH_RUN: begin
                        if (cnt_up >= CNT_W'(r_run_steps)) begin
                            n_phase = stramp_pkg::PH_DECEL;
                            n_count = CNT_W'(r_dec_steps);
                        end else begin
                            n_count = cnt_up;
                        end
                    end
                    stramp_pkg::PH_STOP: begin
                        n_count = '0;
                        n_rem   = '0;
                    end
                    default: n_count = r_count;
                endcase
            end
            stramp_pkg::ST_TICK_END: begin
                n_rem = r_dr[stramp_pkg::REM_W-1:0];
                if (r_phase == stramp_pkg::PH_ACCEL) begin
                    n_delay = (r_dq > DW'(r_delay)) ? '0
                                                    : r_delay - r_dq[DELAY_BITS-1:0];
                    if (r_count >= CNT_W'(r_acc_steps)) begin
                        if (r_run_steps == '0) begin
                            n_phase = stramp_pkg::PH_DECEL;
                            n_count = CNT_W'(r_dec_steps);
                        end else begin
                            n_phase = stramp_pkg::PH_RUN;
                            n_delay = r_floor;
                            n_count = '0;
                        end
                    end
                end else begin
                    n_delay = (dec_sum > {1'b0, DELAY_MAX_D}) ? DELAY_MAX
                                                              : dec_sum[DELAY_BITS-1:0];
                    if (r_count == '0) begin
                        n_phase = stramp_pkg::PH_STOP;
                    end
                end
            end
            stramp_pkg::ST_DIV: begin
                n_dq   = {r_dq[DW-2:0], div_qbit};
                n_dr   = div_qbit ? div_diff[DW-1:0] : div_sh[DW-1:0];
                n_dcnt = r_dcnt + 1'b1;
            end
            stramp_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pulse  = r_pulse;
                    n_out_dir    = r_dir;
                    n_out_period = stramp_pkg::PERIOD_W'(r_delay);
                    n_out_phase  = r_phase;
                end
            end
            default: n_ret = r_ret;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stramp_pkg::ST_IDLE;
            r_ret       <= stramp_pkg::ST_IDLE;
            r_phase     <= stramp_pkg::PH_STOP;
            r_dir       <= 1'b0;
            r_pulse     <= 1'b0;
            r_delay     <= '0;
            r_floor     <= '0;
            r_count     <= '0;
            r_rem       <= '0;
            r_acc_steps <= '0;
            r_run_steps <= '0;
            r_dec_steps <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_phase     <= n_phase;
            r_dir       <= n_dir;
            r_pulse     <= n_pulse;
            r_delay     <= n_delay;
            r_floor     <= n_floor;
            r_count     <= n_count;
            r_rem       <= n_rem;
            r_acc_steps <= n_acc_steps;
            r_run_steps <= n_run_steps;
            r_dec_steps <= n_dec_steps;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_lim_steps  <= n_lim_steps;
        r_acc        <= n_acc;
        r_dec        <= n_dec;
        r_prod       <= n_prod;
        r_dq         <= n_dq;
        r_dr         <= n_dr;
        r_dd         <= n_dd;
        r_dcnt       <= n_dcnt;
        r_sv         <= n_sv;
        r_sr         <= n_sr;
        r_sbit       <= n_sbit;
        r_out_pulse  <= n_out_pulse;
        r_out_dir    <= n_out_dir;
        r_out_period <= n_out_period;
        r_out_phase  <= n_out_phase;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rate  <= 16'd1000;
            r_decel_rate  <= 16'd1000;
            r_top_speed   <= 16'd1000;
            r_speed_scale <= 32'd1000000;
            r_start_scale <= 32'd1000000;
            r_limit_scale <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[stramp_pkg::APB_ADDR_W-1:2])
                stramp_pkg::REG_ACCEL_RATE:  r_accel_rate  <= pwdata[15:0];
                stramp_pkg::REG_DECEL_RATE:  r_decel_rate  <= pwdata[15:0];
                stramp_pkg::REG_TOP_SPEED:   r_top_speed   <= pwdata[15:0];
                stramp_pkg::REG_SPEED_SCALE: r_speed_scale <= pwdata;
                stramp_pkg::REG_START_SCALE: r_start_scale <= pwdata;
                stramp_pkg::REG_LIMIT_SCALE: r_limit_scale <= pwdata;
                default: r_accel_rate <= r_accel_rate;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[stramp_pkg::APB_ADDR_W-1:2])
            stramp_pkg::REG_ACCEL_RATE:  prdata = 32'(r_accel_rate);
            stramp_pkg::REG_DECEL_RATE:  prdata = 32'(r_decel_rate);
            stramp_pkg::REG_TOP_SPEED:   prdata = 32'(r_top_speed);
            stramp_pkg::REG_SPEED_SCALE: prdata = r_speed_scale;
            stramp_pkg::REG_START_SCALE: prdata = r_start_scale;
            stramp_pkg::REG_LIMIT_SCALE: prdata = r_limit_scale;
            default:                     prdata = '0;
        endcase
    end

endmodule
